/* rtl/core/hsbp_pkg.sv */
`timescale 1ns / 1ps

package hsbp_pkg;

   // request kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_ENCODE = 1'b1;

   // fixed field widths
   localparam int SYMBOL_BITS     = 9;
   localparam int CODE_FIELD_BITS = 16;
   localparam int LEN_BITS        = 5;
   localparam int BYTE_BITS       = 8;

   // table shape
   localparam int SYMBOL_COUNT  = 257;
   localparam int MAX_CODE_BITS = 16;
   localparam int END_SYMBOL    = SYMBOL_COUNT - 1;
   localparam int ADDR_BITS     = $clog2(SYMBOL_COUNT);

   // longest code actually stored
   localparam int CODE_BITS = (MAX_CODE_BITS < CODE_FIELD_BITS) ? MAX_CODE_BITS
                                                                : CODE_FIELD_BITS;

   // one table entry: length above code word
   localparam int ENTRY_BITS = LEN_BITS + CODE_FIELD_BITS;

   // accumulator holds pending bits plus one code
   localparam int ACC_BITS   = BYTE_BITS + CODE_BITS;
   localparam int CNT_BITS   = $clog2(BYTE_BITS + (2 ** LEN_BITS));
   localparam int BURST_BITS = CNT_BITS - 3;

   typedef struct packed {
      logic valid;
      logic is_end;
   } s1_type;

endpackage

/* rtl/core/hsbp_req_if.sv */
`timescale 1ns / 1ps

interface hsbp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [hsbp_pkg::SYMBOL_BITS-1:0]      symbol;
   logic [hsbp_pkg::CODE_FIELD_BITS-1:0]  load_code;
   logic [hsbp_pkg::LEN_BITS-1:0]         load_length;

   modport source (output valid, req_type, symbol, load_code, load_length, input ready);
   modport sink   (input valid, req_type, symbol, load_code, load_length, output ready);
endinterface

/* rtl/core/hsbp_rsp_if.sv */
`timescale 1ns / 1ps

interface hsbp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hsbp_pkg::BYTE_BITS-1:0]    out_byte;
   logic                              has_data;
   logic                              last;

   modport source (output valid, out_byte, has_data, last, input ready);
   modport sink   (input valid, out_byte, has_data, last, output ready);
endinterface

/* rtl/core/huffman_symbol_bit_packer_unit.sv */
// Huffman bit packer: load items (req_type 0) write one code table entry, saturating the
// length to 16 and clearing code bits above it; encode items (req_type 1) look the symbol
// up and append its code lsb first to a byte accumulator, and each full byte leaves as one
// result. Symbol 256 ends the stream: after its own code bytes comes one result marked
// last that holds the leftover bits zero-padded, or is flagged empty with has_data low,
// and the accumulator clears. Symbols above 256 are dropped. The table is a single-port
// write, single-port read memory with registered read data, read as an encode item enters
// stage one; results leave from burst registers. The block takes one item per cycle while
// no earlier burst of results waits to drain; an item with results (up to three) holds
// back later items with results until its last is taken, as the output drains one byte
// per handshake. Encoding a symbol whose entry was never loaded gives undefined results.
`timescale 1ns / 1ps

module huffman_symbol_bit_packer_unit (
   input logic        clock,
   input logic        reset,
   hsbp_req_if.sink   req_chan,
   hsbp_rsp_if.source rsp_chan
);

   localparam int AW = hsbp_pkg::ADDR_BITS;

   logic                                  req_fire;
   logic                                  in_range;
   logic                                  wr_en;
   logic                                  rd_en;
   logic [AW-1:0]                         addr;
   logic [hsbp_pkg::LEN_BITS-1:0]         len_sat;
   logic [hsbp_pkg::CODE_FIELD_BITS:0]    code_mask;
   logic [hsbp_pkg::ENTRY_BITS-1:0]       wr_entry;
   logic [hsbp_pkg::ENTRY_BITS-1:0]       rd_entry;
   logic                                  take;
   hsbp_pkg::s1_type                      s1_ff, s1_in;

   // input side: stage one is free or moves on this cycle
   assign req_chan.ready = !s1_ff.valid || take;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_range       = (32'(req_chan.symbol) < 32'(hsbp_pkg::SYMBOL_COUNT));
   assign addr           = AW'(req_chan.symbol);

   // table write path, length saturated and stray code bits cleared
   always_comb begin
      if (req_chan.load_length > hsbp_pkg::LEN_BITS'(hsbp_pkg::CODE_BITS)) begin
         len_sat = hsbp_pkg::LEN_BITS'(hsbp_pkg::CODE_BITS);
      end else begin
         len_sat = req_chan.load_length;
      end
      code_mask = ((hsbp_pkg::CODE_FIELD_BITS+1)'(1) << len_sat)
                - (hsbp_pkg::CODE_FIELD_BITS+1)'(1);
      wr_entry  = {len_sat,
                   req_chan.load_code & code_mask[hsbp_pkg::CODE_FIELD_BITS-1:0]};
   end

   assign wr_en = req_fire && in_range && (req_chan.req_type == hsbp_pkg::REQ_LOAD);
   assign rd_en = req_fire && in_range && (req_chan.req_type == hsbp_pkg::REQ_ENCODE);

   // read data holds while stage one waits, since no new read is issued then
   hsbp_code_ram #(
      .DEPTH (hsbp_pkg::SYMBOL_COUNT),
      .WIDTH (hsbp_pkg::ENTRY_BITS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   // stage one tracks the encode item whose table read is in flight
   always_comb begin
      s1_in = s1_ff;
      if (req_chan.ready) begin
         s1_in.valid  = rd_en;
         s1_in.is_end = (32'(req_chan.symbol) == 32'(hsbp_pkg::END_SYMBOL));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   hsbp_pack_stage u_pack (
      .clock     (clock),
      .reset     (reset),
      .s1        (s1_ff),
      .code_word (rd_entry[hsbp_pkg::CODE_FIELD_BITS-1:0]),
      .code_len  (rd_entry[hsbp_pkg::ENTRY_BITS-1:hsbp_pkg::CODE_FIELD_BITS]),
      .take      (take),
      .rsp_chan  (rsp_chan)
   );

   // a load never puts an item into stage one
   a_load_no_s1 : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.req_type == hsbp_pkg::REQ_LOAD)) |=> !s1_ff.valid)
      else $error("load item entered the encode stage");

   // only the final result may be empty
   a_empty_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.has_data) |-> rsp_chan.last)
      else $error("empty result not marked last");

   // an empty final marker carries a zero byte
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.has_data) |-> (rsp_chan.out_byte == '0))
      else $error("empty final result has nonzero byte");

endmodule

/* rtl/core/hsbp_code_ram.sv */
`timescale 1ns / 1ps

module hsbp_code_ram #(
   parameter int DEPTH = 257,
   parameter int WIDTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/hsbp_pack_stage.sv */
`timescale 1ns / 1ps

module hsbp_pack_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hsbp_pkg::s1_type                      s1,
   input  logic [hsbp_pkg::CODE_FIELD_BITS-1:0]  code_word,
   input  logic [hsbp_pkg::LEN_BITS-1:0]         code_len,
   output logic                                  take,
   hsbp_rsp_if.source                            rsp_chan
);

   localparam int ACC = hsbp_pkg::ACC_BITS;
   localparam int CNT = hsbp_pkg::CNT_BITS;
   localparam int BB  = hsbp_pkg::BURST_BITS;
   localparam int BYT = hsbp_pkg::BYTE_BITS;

   // accumulator state
   logic [BYT-1:0] pend_bits_ff, pend_bits_in;
   logic [2:0]     pend_cnt_ff, pend_cnt_in;

   // result burst of one item, drained one byte per handshake
   logic [ACC-1:0] burst_data_ff, burst_data_in;
   logic [BB-1:0]  bytes_left_ff, bytes_left_in;
   logic           last_ff, last_in;
   logic           has_ff, has_in;

   logic [ACC-1:0] acc;
   logic [ACC:0]   mask_wide;
   logic [ACC-1:0] acc_m;
   logic [ACC-1:0] acc_shift;
   logic [CNT-1:0] count;
   logic [BB-1:0]  nbytes;
   logic           zero_out;
   logic           burst_busy;
   logic           burst_ends;
   logic           rsp_fire;

   always_comb begin
      acc       = (ACC'(code_word) << pend_cnt_ff) | ACC'(pend_bits_ff);
      count     = CNT'(pend_cnt_ff) + CNT'(code_len);
      mask_wide = ((ACC+1)'(1) << count) - (ACC+1)'(1);
      acc_m     = acc & mask_wide[ACC-1:0];
      nbytes    = count[CNT-1:3];
      acc_shift = acc_m >> {nbytes, 3'b000};
      zero_out  = (nbytes == '0) && !s1.is_end;
   end

   assign burst_busy = (bytes_left_ff != '0) || last_ff;
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   // the burst empties on this handshake
   assign burst_ends = rsp_fire && (((bytes_left_ff == BB'(1)) && !last_ff) ||
                                    (bytes_left_ff == '0));
   assign take = s1.valid && (zero_out || !burst_busy || burst_ends);

   always_comb begin
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      burst_data_in = burst_data_ff;
      bytes_left_in = bytes_left_ff;
      last_in       = last_ff;
      has_in        = has_ff;
      if (take) begin
         if (s1.is_end) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            pend_bits_in = acc_shift[BYT-1:0];
            pend_cnt_in  = count[2:0];
         end
      end
      if (take && !zero_out) begin
         burst_data_in = acc_m;
         bytes_left_in = nbytes;
         last_in       = s1.is_end;
         has_in        = (count[2:0] != 3'd0);
      end else if (rsp_fire) begin
         burst_data_in = burst_data_ff >> BYT;
         if (bytes_left_ff != '0) begin
            bytes_left_in = bytes_left_ff - BB'(1);
         end else begin
            last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_cnt_ff   <= '0;
         bytes_left_ff <= '0;
         last_ff       <= 1'b0;
      end else begin
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
         bytes_left_ff <= bytes_left_in;
         last_ff       <= last_in;
      end
      burst_data_ff <= burst_data_in;
      has_ff        <= has_in;
   end

   assign rsp_chan.valid    = burst_busy;
   assign rsp_chan.out_byte = burst_data_ff[BYT-1:0];
   assign rsp_chan.has_data = (bytes_left_ff != '0) || has_ff;
   assign rsp_chan.last     = (bytes_left_ff == '0) && last_ff;

endmodule

/* bench/hsbp_checker.sv */
`timescale 1ns / 1ps

module hsbp_checker
   import hsbp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hsbp_req_if  req_mon,
   hsbp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   bytes_checked,
   output int   ends_checked
);

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 has_data;
      logic                 last;
   } packed_byte_type;

   // shadow of the code table and the bit accumulator
   logic [CODE_FIELD_BITS-1:0] code_word [SYMBOL_COUNT];
   int unsigned                code_len  [SYMBOL_COUNT];
   logic [BYTE_BITS-1:0]       pend_bits;
   int unsigned                pend_cnt;
   packed_byte_type            expected_bytes [$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      bytes_checked = 0;
      ends_checked  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t ns] mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic void push_byte(logic [BYTE_BITS-1:0] value, logic has, logic fin);
      packed_byte_type item;
      item.out_byte = value;
      item.has_data = has;
      item.last     = fin;
      expected_bytes.push_back(item);
   endfunction

   function automatic void load_entry(int unsigned sym, logic [CODE_FIELD_BITS-1:0] code,
                                      logic [LEN_BITS-1:0] len);
      int unsigned n;
      n = (32'(len) > CODE_BITS) ? CODE_BITS : 32'(len);
      code_len[sym]  = n;
      code_word[sym] = code & CODE_FIELD_BITS'((32'd1 << n) - 32'd1);
   endfunction

   // append one code lsb first, emit every full byte, close the stream on the end symbol
   function automatic void pack_symbol(int unsigned sym);
      logic [31:0] acc;
      int unsigned cnt;
      acc = {24'd0, pend_bits} | ({16'd0, code_word[sym]} << pend_cnt);
      cnt = pend_cnt + code_len[sym];
      while (cnt >= BYTE_BITS) begin
         push_byte(acc[7:0], 1'b1, 1'b0);
         acc = acc >> BYTE_BITS;
         cnt -= BYTE_BITS;
      end
      if (sym == END_SYMBOL) begin
         if (cnt > 0)
            push_byte(acc[7:0] & ((8'd1 << cnt) - 8'd1), 1'b1, 1'b1);
         else
            push_byte(8'd0, 1'b0, 1'b1);
         pend_bits = '0;
         pend_cnt  = 0;
      end else begin
         pend_bits = acc[7:0] & ((8'd1 << cnt) - 8'd1);
         pend_cnt  = cnt;
      end
   endfunction

   always @(posedge clock) begin : watch
      packed_byte_type want;
      if (reset) begin
         pend_bits = '0;
         pend_cnt  = 0;
      end else begin
         if (req_mon.valid && req_mon.ready && req_mon.symbol < SYMBOL_COUNT) begin
            if (req_mon.req_type == REQ_LOAD)
               load_entry(32'(req_mon.symbol), req_mon.load_code, req_mon.load_length);
            else
               pack_symbol(32'(req_mon.symbol));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: byte %h has_data %b last %b",
                                         rsp_mon.out_byte, rsp_mon.has_data, rsp_mon.last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_mon.out_byte, want.out_byte));
               if (rsp_mon.has_data !== want.has_data)
                  report_mismatch($sformatf("has_data %b, expected %b",
                                            rsp_mon.has_data, want.has_data));
               if (rsp_mon.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_mon.last, want.last));
               bytes_checked++;
               if (want.last)
                  ends_checked++;
            end
         end
      end
      outstanding = expected_bytes.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import hsbp_pkg::*;

   // receiver stall patterns
   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_PERIODIC, FLOW_CHOKED} flow_mode_type;

   logic clock;
   logic reset;

   int fail_count;
   int outstanding;
   int bytes_checked;
   int ends_checked;

   hsbp_req_if req_chan ();
   hsbp_rsp_if rsp_chan ();

   huffman_symbol_bit_packer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hsbp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked),
      .ends_checked  (ends_checked)
   );

   // sender bookkeeping: which table entries hold a code, so no unwritten entry is encoded
   bit          symbol_loaded [SYMBOL_COUNT];
   int          loaded_syms [$];
   int          burst_left;
   int          load_items;
   int          encode_items;
   int          ignored_items;

   flow_mode_type flow_mode;
   int            flow_timer;

   always #1 clock = ~clock;

   // receiver: switches between free flow, coin flips, a periodic stall and heavy choking
   always @(negedge clock) begin
      if (flow_timer == 0) begin
         flow_mode  = flow_mode_type'($urandom_range(0, 3));
         flow_timer = $urandom_range(20, 80);
      end else begin
         flow_timer--;
      end
      case (flow_mode)
         FLOW_FREE:     rsp_chan.ready = 1'b1;
         FLOW_COIN:     rsp_chan.ready = ($urandom_range(0, 1) == 1);
         FLOW_PERIODIC: rsp_chan.ready = (flow_timer % 5 != 0);
         default:       rsp_chan.ready = ($urandom_range(0, 7) == 0);
      endcase
   end

   // hand one item over; called and returning at a falling edge, valid stays up between items of a burst
   task automatic send_item(input logic kind, input int sym, input int code, input int len);
      if (burst_left == 0) begin
         // gap between bursts, then a short or a long burst
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_chan.valid       = 1'b1;
      req_chan.req_type    = kind;
      req_chan.symbol      = SYMBOL_BITS'(sym);
      req_chan.load_code   = CODE_FIELD_BITS'(code);
      req_chan.load_length = LEN_BITS'(len);
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      burst_left--;
      if (sym >= SYMBOL_COUNT) begin
         ignored_items++;
      end else if (kind == REQ_LOAD) begin
         load_items++;
         if (!symbol_loaded[sym]) begin
            symbol_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
         end
      end else begin
         encode_items++;
      end
   endtask

   // hold the sender until every expected byte is out
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // mostly short codes, with empty, full length and overlong lengths mixed in
   function automatic int random_length();
      case ($urandom_range(0, 19))
         0:       return 0;
         1:       return 16;
         2:       return $urandom_range(17, 31);
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   task automatic load_random_entry(input int sym);
      send_item(REQ_LOAD, sym, $urandom_range(0, 'hffff), random_length());
   endtask

   task automatic encode_symbol(input int sym);
      send_item(REQ_ENCODE, sym, $urandom_range(0, 'hffff), $urandom_range(0, 31));
   endtask

   // one stream of loaded symbols with some noise, usually closed by the end symbol
   task automatic run_stream();
      int n_syms;
      n_syms = $urandom_range(2, 20);
      for (int i = 0; i < n_syms; i++) begin
         case ($urandom_range(0, 19))
            0:       encode_symbol($urandom_range(SYMBOL_COUNT, 511));
            1:       load_random_entry($urandom_range(SYMBOL_COUNT, 511));
            // rewrite an entry mid stream, possibly one that is about to be encoded
            2:       load_random_entry(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            default: encode_symbol(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
         endcase
      end
      // now and then a stream runs on into the next one without its end symbol
      if ($urandom_range(0, 7) != 0)
         encode_symbol(END_SYMBOL);
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_LOAD;
      req_chan.symbol      = '0;
      req_chan.load_code   = '0;
      req_chan.load_length = '0;
      rsp_chan.ready       = 1'b0;
      flow_mode            = FLOW_FREE;
      flow_timer           = 0;
      burst_left           = 0;
      load_items           = 0;
      encode_items         = 0;
      ignored_items        = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // end symbol with an empty code and stray code bits that must be dropped
      send_item(REQ_LOAD, END_SYMBOL, 'hffff, 0);
      // full length code of all ones
      send_item(REQ_LOAD, 0, 'hffff, 16);
      // overlong length saturates to sixteen
      send_item(REQ_LOAD, 255, 'ha5a5, 31);
      send_item(REQ_LOAD, 1, 'h0001, 1);
      // zero length code on an ordinary symbol
      send_item(REQ_LOAD, 2, 'h0000, 0);
      // loads past the table end are dropped
      send_item(REQ_LOAD, 511, 'h5a5a, 7);
      send_item(REQ_LOAD, 257, 'h00ff, 8);

      // end of stream with nothing pending gives an empty final item
      encode_symbol(END_SYMBOL);

      // multi byte codes, a silent symbol, ignored encodes and a padded tail
      encode_symbol(1);
      encode_symbol(0);
      encode_symbol(255);
      encode_symbol(2);
      encode_symbol(511);
      encode_symbol(258);
      encode_symbol(END_SYMBOL);

      // seven pending bits plus a sixteen bit end code: two bytes and a last item
      send_item(REQ_LOAD, END_SYMBOL, 'h1234, 16);
      for (int i = 0; i < 7; i++)
         encode_symbol(1);
      encode_symbol(END_SYMBOL);

      wait_drained();

      // random part: table updates between streams, with an occasional full drain
      while (load_items + encode_items < 145) begin
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6)) load_random_entry($urandom_range(0, END_SYMBOL));
         run_stream();
         if ($urandom_range(0, 3) == 0)
            wait_drained();
      end

      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      // let anything the block still holds show up as a stray item
      repeat (20) @(negedge clock);

      $display("covered %0d table loads, %0d encodes and %0d dropped items",
               load_items, encode_items, ignored_items);
      $display("checked %0d output bytes across %0d stream ends", bytes_checked, ends_checked);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #400000;
      $display("timeout with %0d items still expected", outstanding);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
rtl/core/hsbp_pkg.sv
rtl/core/hsbp_req_if.sv
rtl/core/hsbp_rsp_if.sv
rtl/core/hsbp_code_ram.sv
rtl/core/hsbp_pack_stage.sv
rtl/core/huffman_symbol_bit_packer_unit.sv
bench/hsbp_checker.sv
bench/testbench.sv
